// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptp_pkg.sv =====
`default_nettype none

package ptp_pkg;

    // Text limits and saturation points
    localparam logic [15:0] MAX_TEXT_LEN = 16'hFFFF;
    localparam logic [30:0] MAG_MAX      = 31'h7FFF_FFFF;
    localparam logic [15:0] POW_MAX      = 16'hFFFF;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Result queue size
    localparam int Q_DEPTH = 4;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_SIGNED = 4'd1,
        PH_COEF   = 4'd2,
        PH_VAR    = 4'd3,
        PH_CARET  = 4'd4,
        PH_EXP    = 4'd5,
        PH_AFTER  = 4'd6,
        PH_DRAIN  = 4'd7
    } t_phase;

    typedef enum logic [2:0] {
        K_TERM   = 3'd0,
        K_END    = 3'd1,
        K_NOCOEF = 3'd2,
        K_NOEXP  = 3'd3,
        K_BADCH  = 3'd4
    } t_kind;

    typedef struct packed {
        logic       action;
        logic [7:0] character;
    } t_request;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] coefficient;
        logic [15:0]        exponent;
        logic [15:0]        position;
        logic               last;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic        negative;
        logic [30:0] magnitude;
        logic [15:0] power;
        logic [15:0] char_index;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:      PH_START,
        negative:   1'b0,
        magnitude:  31'd0,
        power:      16'd0,
        char_index: 16'd0
    };

endpackage

`default_nettype wire

// ===== rtl/polynomial_term_parser.sv =====
// Streaming polynomial term parser.
// Input channel (i_valid, i_req, o_stall): one request per text byte, or an
// end-of-string marker with action set. A request is taken at a clock edge
// with i_valid high and o_stall low.
// Output channel (o_valid, o_res, i_stall): one result per handshake; terms,
// errors with their position, and an end result closing each string. The
// last flag marks the final result caused by a request.
// Results of a request enter the result queue as it is taken. Throughput:
// one byte per cycle while o_stall is low and bytes give at most one
// result; a byte giving two results (term plus bad character, or term
// plus end) queues both at once. A four-entry result queue decouples the
// sides; o_stall rises when fewer than two entries are free.
// Reset clears the parse state and empties the queue. When the receiver
// stalls, the head result holds and the queue fills until o_stall rises.
`default_nettype none

module polynomial_term_parser (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire ptp_pkg::t_request i_req,
    output logic                   o_stall,
    output logic                   o_valid,
    output ptp_pkg::t_result       o_res,
    input  wire                    i_stall
);
    import ptp_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [1:0]         step_cnt;
    t_result            step_res0;
    t_result            step_res1;
    logic [Q_CNT_W-1:0] q_count;
    logic               in_acc;
    logic               out_acc;
    logic [1:0]         push_cnt;

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = o_valid && !i_stall;
    assign push_cnt = in_acc ? step_cnt : 2'd0;

    ptp_step u_step (
        .i_state (r_state),
        .i_req   (i_req),
        .o_next  (n_state),
        .o_cnt   (step_cnt),
        .o_res0  (step_res0),
        .o_res1  (step_res1)
    );

    // Parse state advances on every taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    ptp_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push0    (step_res0),
        .i_push1    (step_res1),
        .i_pop      (out_acc),
        .o_head     (o_res),
        .o_count    (q_count)
    );

    // Hold off requests unless two queue entries are free
    assign o_stall = (q_count > Q_CNT_W'(Q_DEPTH - 2));
    assign o_valid = (q_count != '0);

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_q_bound, i_clk, i_rst_n, q_count <= Q_CNT_W'(Q_DEPTH), "queue overflow")
    `ASSERT_NEXT(a_end_out, i_clk, i_rst_n, in_acc && i_req.action, o_valid, "end lost")
    `ASSERT_NEXT(a_end_rst, i_clk, i_rst_n, in_acc && i_req.action, r_state.phase == PH_START && r_state.char_index == 16'd0, "state not cleared at end")
    `ASSERT_ALWAYS(a_end_last, i_clk, i_rst_n, !o_valid || o_res.kind != K_END || o_res.last, "end without last")

endmodule

`default_nettype wire

// ===== rtl/ptp_step.sv =====
`default_nettype none

module ptp_step (
    input  wire ptp_pkg::t_state   i_state,
    input  wire ptp_pkg::t_request i_req,
    output ptp_pkg::t_state        o_next,
    output logic [1:0]             o_cnt,
    output ptp_pkg::t_result       o_res0,
    output ptp_pkg::t_result       o_res1
);
    import ptp_pkg::*;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= 8'h39);
    endfunction

    function automatic logic is_let(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic t_result mk_res(input t_kind k, input logic [15:0] pos);
        t_result r;
        r             = '0;
        r.kind        = k;
        r.position    = pos;
        return r;
    endfunction

    logic [7:0]  ch;
    logic [3:0]  digit;
    logic [34:0] mag_acc;
    logic [30:0] mag_sat;
    logic [19:0] pow_acc;
    logic [15:0] pow_sat;
    logic [31:0] mag_ext;
    t_result     term_res;
    t_result     res0;
    t_result     res1;
    t_state      nxt;
    logic [1:0]  cnt;

    assign ch    = i_req.character;
    assign digit = 4'(ch - CH_ZERO);

    // Decimal accumulate with saturation
    assign mag_acc = ({4'b0, i_state.magnitude} << 3) + ({4'b0, i_state.magnitude} << 1)
                   + 35'(digit);
    assign mag_sat = (mag_acc > 35'(MAG_MAX)) ? MAG_MAX : mag_acc[30:0];
    assign pow_acc = ({4'b0, i_state.power} << 3) + ({4'b0, i_state.power} << 1)
                   + 20'(digit);
    assign pow_sat = (pow_acc > 20'(POW_MAX)) ? POW_MAX : pow_acc[15:0];

    // Finished term from the current state
    assign mag_ext = {1'b0, i_state.magnitude};
    always_comb begin
        term_res             = '0;
        term_res.kind        = K_TERM;
        term_res.coefficient = i_state.negative ? (32'd0 - mag_ext) : mag_ext;
        term_res.exponent    = i_state.power;
    end

    // Parse one request
    always_comb begin
        nxt  = i_state;
        cnt  = 2'd0;
        res0 = '0;
        res1 = '0;

        if (i_req.action) begin
            case (i_state.phase)
                PH_SIGNED: begin
                    res0 = mk_res(K_NOCOEF, i_state.char_index);
                    cnt  = 2'd1;
                end
                PH_CARET: begin
                    res0 = mk_res(K_NOEXP, i_state.char_index);
                    cnt  = 2'd1;
                end
                PH_COEF, PH_VAR, PH_EXP: begin
                    res0 = term_res;
                    cnt  = 2'd1;
                end
                default: begin
                end
            endcase
            if (cnt == 2'd0) begin
                res0      = mk_res(K_END, 16'd0);
                res0.last = 1'b1;
                cnt       = 2'd1;
            end else begin
                res1      = mk_res(K_END, 16'd0);
                res1.last = 1'b1;
                cnt       = 2'd2;
            end
            nxt = STATE_RESET;
        end else begin
            case (i_state.phase)
                PH_START, PH_SIGNED: begin
                    if (is_ws(ch)) begin
                    end else if (i_state.phase == PH_START && is_sign(ch)) begin
                        nxt.magnitude = '0;
                        nxt.power     = '0;
                        nxt.negative  = (ch == CH_MINUS);
                        nxt.phase     = PH_SIGNED;
                    end else if (is_dig(ch)) begin
                        nxt.magnitude = 31'(digit);
                        nxt.phase     = PH_COEF;
                    end else if (is_let(ch)) begin
                        nxt.magnitude = 31'd1;
                        nxt.power     = 16'd1;
                        nxt.phase     = PH_VAR;
                    end else begin
                        res0      = mk_res(K_NOCOEF, i_state.char_index);
                        cnt       = 2'd1;
                        nxt.phase = PH_DRAIN;
                    end
                end
                PH_COEF, PH_VAR, PH_EXP: begin
                    if (i_state.phase == PH_COEF && is_dig(ch)) begin
                        nxt.magnitude = mag_sat;
                    end else if (i_state.phase == PH_COEF && is_let(ch)) begin
                        nxt.power = 16'd1;
                        nxt.phase = PH_VAR;
                    end else if (i_state.phase == PH_VAR && ch == CH_CARET) begin
                        nxt.phase = PH_CARET;
                    end else if (i_state.phase == PH_EXP && is_dig(ch)) begin
                        nxt.power = pow_sat;
                    end else begin
                        // Close the term, then look at the byte that closed it
                        res0          = term_res;
                        cnt           = 2'd1;
                        nxt.negative  = 1'b0;
                        nxt.magnitude = '0;
                        nxt.power     = '0;
                        if (is_ws(ch)) begin
                            nxt.phase = PH_AFTER;
                        end else if (is_sign(ch)) begin
                            nxt.negative = (ch == CH_MINUS);
                            nxt.phase    = PH_SIGNED;
                        end else begin
                            res1      = mk_res(K_BADCH, i_state.char_index);
                            cnt       = 2'd2;
                            nxt.phase = PH_DRAIN;
                        end
                    end
                end
                PH_CARET: begin
                    if (is_dig(ch)) begin
                        nxt.power = 16'(digit);
                        nxt.phase = PH_EXP;
                    end else begin
                        res0      = mk_res(K_NOEXP, i_state.char_index);
                        cnt       = 2'd1;
                        nxt.phase = PH_DRAIN;
                    end
                end
                PH_AFTER: begin
                    if (is_ws(ch)) begin
                    end else if (is_sign(ch)) begin
                        nxt.magnitude = '0;
                        nxt.power     = '0;
                        nxt.negative  = (ch == CH_MINUS);
                        nxt.phase     = PH_SIGNED;
                    end else begin
                        res0      = mk_res(K_BADCH, i_state.char_index);
                        cnt       = 2'd1;
                        nxt.phase = PH_DRAIN;
                    end
                end
                default: begin
                    nxt.phase = PH_DRAIN;
                end
            endcase

            // Advance the index, holding at the limit
            if (i_state.char_index != MAX_TEXT_LEN) begin
                nxt.char_index = i_state.char_index + 16'd1;
            end

            // Flag the final result of this request
            if (cnt == 2'd1) begin
                res0.last = 1'b1;
            end else if (cnt == 2'd2) begin
                res1.last = 1'b1;
            end
        end
    end

    assign o_next = nxt;
    assign o_cnt  = cnt;
    assign o_res0 = res0;
    assign o_res1 = res1;

endmodule

`default_nettype wire

// ===== rtl/ptp_outq.sv =====
`default_nettype none

module ptp_outq (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire [1:0]                   i_push_cnt,
    input  wire ptp_pkg::t_result       i_push0,
    input  wire ptp_pkg::t_result       i_push1,
    input  wire                         i_pop,
    output ptp_pkg::t_result            o_head,
    output logic [ptp_pkg::Q_CNT_W-1:0] o_count
);
    import ptp_pkg::*;

    t_result              r_q [Q_DEPTH];
    t_result              n_q [Q_DEPTH];
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_CNT_W-1:0]   n_count;
    logic [Q_CNT_W-1:0]   base;

    // Shift on pop, then append up to two results behind the survivors
    assign base = r_count - Q_CNT_W'(i_pop);

    always_comb begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (i_pop && i < Q_DEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (i_push_cnt != 2'd0 && base == Q_CNT_W'(i)) begin
                n_q[i] = i_push0;
            end
            if (i_push_cnt == 2'd2 && base + Q_CNT_W'(1) == Q_CNT_W'(i)) begin
                n_q[i] = i_push1;
            end
        end
        n_count = base + Q_CNT_W'(i_push_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_head  = r_q[0];
    assign o_count = r_count;

endmodule

`default_nettype wire
